FILE: design/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_ADD_FRONT    = 3'd0;
   localparam op_type OP_ADD_BACK     = 3'd1;
   localparam op_type OP_REMOVE_FRONT = 3'd2;
   localparam op_type OP_REMOVE_BACK  = 3'd3;
   localparam op_type OP_MEMBER       = 3'd4;

   localparam status_type STS_OK    = 2'd0;
   localparam status_type STS_EMPTY = 2'd1;
   localparam status_type STS_FULL  = 2'd2;

endpackage

FILE: design/bdq_if.sv
`timescale 1ns / 1ps

interface bdq_req_if;
   logic                  valid;
   logic                  ready;
   bdq_pkg::op_type       operation;
   logic signed [31:0]    item_value;

   modport source (output valid, output operation, output item_value, input ready);
   modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface bdq_rsp_if;
   logic                  valid;
   logic                  ready;
   bdq_pkg::status_type   status;
   logic                  found;

   modport source (output valid, output status, output found, input ready);
   modport sink   (input valid, input status, input found, output ready);
endinterface

FILE: design/bdq_ram.sv
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/bounded_deque_with_search_top.sv
`timescale 1ns / 1ps
// Channel    Dir  Payload                       Accepted when
// req_chan   in   operation[2:0], item_value    valid && ready
// rsp_chan   out  status[1:0], found            valid && ready
//
// Inserts and removals: result registered at the accepting edge.
// Membership test: entries read one per cycle from the single-port-read
// entry RAM (stops early on a match); an empty queue answers not found.
// One request in flight; a new request is taken while the result register
// is empty or being drained. Synchronous reset empties the queue at once.

module bounded_deque_with_search_top #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CAPACITY - 1);
   localparam logic [ADDR_W:0]   CAP_SUM  = (ADDR_W + 1)'(CAPACITY);

   localparam logic STATE_IDLE   = 1'b0;
   localparam logic STATE_SEARCH = 1'b1;

   logic                  state_ff, state_in;
   logic [ADDR_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   bdq_pkg::value_type    key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bdq_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                  rsp_found_ff, rsp_found_in;

   logic                  accept;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   bdq_pkg::value_type    rd_data;
   logic                  is_full;
   logic                  is_empty;

   function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] base,
                                              input logic [ADDR_W-1:0] off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign req_chan.ready  = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.found  = rsp_found_ff;

   assign is_full  = (count_ff == CAP_CNT);
   assign is_empty = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = slot(front_ff, idx_ff[ADDR_W-1:0]);

      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bdq_pkg::STS_OK;
               rsp_found_in  = 1'b0;
               unique case (req_chan.operation)
                  bdq_pkg::OP_ADD_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = bdq_pkg::STS_FULL;
                     end else begin
                        front_in = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  bdq_pkg::OP_ADD_BACK: begin
                     if (is_full) begin
                        rsp_status_in = bdq_pkg::STS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot(front_ff, count_ff[ADDR_W-1:0]);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  bdq_pkg::OP_REMOVE_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = bdq_pkg::STS_EMPTY;
                     end else begin
                        front_in = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  bdq_pkg::OP_REMOVE_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = bdq_pkg::STS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  bdq_pkg::OP_MEMBER: begin
                     if (!is_empty) begin
                        rsp_valid_in = 1'b0;
                        state_in     = STATE_SEARCH;
                        idx_in       = '0;
                        key_in       = req_chan.item_value;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         STATE_SEARCH: begin
            if (pend_ff && (rd_data == key_ff)) begin
               state_in      = STATE_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bdq_pkg::STS_OK;
               rsp_found_in  = 1'b1;
            end else if (idx_ff == count_ff) begin
               state_in      = STATE_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bdq_pkg::STS_OK;
               rsp_found_in  = 1'b0;
            end else begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   bdq_ram #(
      .WIDTH (bdq_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.item_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_search_out_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_SEARCH |-> !rsp_valid_ff)
      else $error("result register busy during search");

   a_search_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_SEARCH |-> idx_ff <= count_ff && count_ff != '0)
      else $error("search index out of range");

   a_member_enters_search: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.operation == bdq_pkg::OP_MEMBER && !is_empty
      |=> state_ff == STATE_SEARCH && $stable(count_ff))
      else $error("membership test did not start a search");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == bdq_pkg::STS_OK)
      else $error("match reported with error status");

endmodule
